/* hw/rtl/swsb_pkg.sv */
// Shared types, constants and codes for the sliding window send buffer.
package swsb_pkg;

    // Fixed field widths.
    localparam int SEQ_W    = 32;
    localparam int REF_W    = 16;
    localparam int LEN_W    = 12;
    localparam int RTY_W    = 4;
    localparam int STS_W    = 3;
    localparam int WS_W     = 7;
    localparam int MR_W     = 4;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Active window size covers every depth up to 1024 slots.
    localparam int SIZE_W   = 11;
    localparam int DEPTH_DEF = 64;

    // Register reset values.
    localparam logic [WS_W-1:0] WS_RST = 7'd64;
    localparam logic [MR_W-1:0] MR_RST = 4'd10;

    // Register indexes on the configuration port.
    typedef enum logic
    {
        REG_WINDOW_SIZE = 1'b0,
        REG_MAX_RESENDS = 1'b1
    } reg_idx_t;

    // Operation codes.
    typedef enum logic [1:0]
    {
        FN_ADD    = 2'd0,
        FN_ACK    = 2'd1,
        FN_GET    = 2'd2,
        FN_RESEND = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [STS_W-1:0]
    {
        STS_OK          = 3'd0,
        STS_COLLISION   = 3'd1,
        STS_NOT_FOUND   = 3'd2,
        STS_RETRY_LIMIT = 3'd3,
        STS_NO_ACK      = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [3:0]
    {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_EXEC,
        S_A1_RD,
        S_A1_CHK,
        S_A1_MOD,
        S_A2_RD,
        S_A2_CHK,
        S_DONE
    } state_t;

    // One slot of the window memory.
    typedef struct packed
    {
        logic              valid;
        logic              acked;
        logic [RTY_W-1:0]  retries;
        logic [SEQ_W-1:0]  seq;
        logic [REF_W-1:0]  pref;
        logic [LEN_W-1:0]  plen;
        logic              plast;
        logic [SIZE_W-1:0] wsz;
    } entry_t;

    // Memory access strobes.
    typedef struct packed
    {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

/* hw/rtl/sliding_window_send_buffer_unit.sv */
// Top level of the sliding window send buffer: configuration registers and wiring.
//
// Request channel (req_valid/req_stall) carries one word per operation: func,
// seq_or_ack and, for add, the payload handle, length and last mark. The
// response channel (rsp_valid/rsp_stall) returns exactly one word per request.
// Slots live in one single-port memory with registered read data, indexed
// by sequence number modulo the active window size.
// The slot index comes from a bit-serial remainder unit. Add, get and resend
// then read the slot and write it back when an add or resend succeeds, before
// the response word is presented. Ack checks each active slot in its marking
// pass (with a further remainder step for a slot stored under a different
// window size) and reads and frees each acked slot while sliding the lower edge.
// One request is in flight at a time; req_stall stays high until it is done.
// A finished word waits in an output register while the next request is taken;
// if rsp_stall holds that register full, the next result waits in its state.
// After reset a clearing pass writes every slot to zero, one slot a cycle,
// while requests stall; the APB port works throughout.
module sliding_window_send_buffer_unit
    import swsb_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        func,
    input  logic [SEQ_W-1:0]  seq_or_ack,
    input  logic [REF_W-1:0]  payload_ref,
    input  logic [LEN_W-1:0]  payload_len,
    input  logic              last_flag,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [STS_W-1:0]  status,
    output logic [REF_W-1:0]  entry_ref,
    output logic [LEN_W-1:0]  entry_len,
    output logic              entry_last,
    output logic [RTY_W-1:0]  entry_retries,
    output logic              window_open,
    output logic              window_empty,
    output logic [SEQ_W-1:0]  lower_edge
);

    localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    logic [WS_W-1:0]   wsize_reg, wsize_next;
    logic [MR_W-1:0]   maxr_reg, maxr_next;
    logic [SIZE_W-1:0] wsize_ext;
    logic [SIZE_W-1:0] act_size;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    mem_ctl_t          mem_ctl;
    logic [IW-1:0]     mem_addr;
    entry_t            mem_wdata;
    entry_t            mem_rdata;
    logic              mod_start;
    logic [SEQ_W-1:0]  mod_dividend;
    logic [SIZE_W-1:0] mod_divisor;
    logic              mod_busy;
    logic [SIZE_W-1:0] mod_rem;

    // Register writes.
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_comb
    begin
        wsize_next = wsize_reg;
        maxr_next  = maxr_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_WINDOW_SIZE: wsize_next = pwdata[WS_W-1:0];
                REG_MAX_RESENDS: maxr_next  = pwdata[MR_W-1:0];
                default:         wsize_next = wsize_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg <= WS_RST;
            maxr_reg  <= MR_RST;
        end
        else
        begin
            wsize_reg <= wsize_next;
            maxr_reg  <= maxr_next;
        end
    end

    // Register reads.
    always_comb
    begin
        case (cfg_idx)
            REG_WINDOW_SIZE: prdata = DATA_W'(wsize_reg);
            REG_MAX_RESENDS: prdata = DATA_W'(maxr_reg);
            default:         prdata = '0;
        endcase
    end

    // Active size: zero acts as one, anything above the depth as the depth.
    assign wsize_ext = SIZE_W'(wsize_reg);
    always_comb
    begin
        if (wsize_ext == '0)
        begin
            act_size = SIZE_W'(1);
        end
        else if (wsize_ext > SIZE_W'(WINDOW_DEPTH))
        begin
            act_size = SIZE_W'(WINDOW_DEPTH);
        end
        else
        begin
            act_size = wsize_ext;
        end
    end

    swsb_ctrl #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .act_size      (act_size),
        .max_resends   (maxr_reg),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .seq_or_ack    (seq_or_ack),
        .payload_ref   (payload_ref),
        .payload_len   (payload_len),
        .last_flag     (last_flag),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .entry_ref     (entry_ref),
        .entry_len     (entry_len),
        .entry_last    (entry_last),
        .entry_retries (entry_retries),
        .window_open   (window_open),
        .window_empty  (window_empty),
        .lower_edge    (lower_edge),
        .mem_ctl       (mem_ctl),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata),
        .mod_start     (mod_start),
        .mod_dividend  (mod_dividend),
        .mod_divisor   (mod_divisor),
        .mod_busy      (mod_busy),
        .mod_rem       (mod_rem)
    );

    swsb_mem #(
        .DEPTH (WINDOW_DEPTH)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    swsb_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .busy     (mod_busy),
        .rem      (mod_rem)
    );

endmodule

/* hw/rtl/swsb_mem.sv */
// Slot memory: one synchronous port, registered read data.
module swsb_mem
    import swsb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                                 clk,
    input  mem_ctl_t                             ctl,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  entry_t                               wdata,
    output entry_t                               rdata
);

    entry_t mem_reg [DEPTH];
    entry_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[addr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/swsb_mod.sv */
// Restoring remainder unit: 32-bit value modulo the window size, one bit a cycle.
module swsb_mod
    import swsb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SEQ_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              busy,
    output logic [SIZE_W-1:0] rem
);

    logic              busy_reg, busy_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [SEQ_W-1:0]  dvd_reg, dvd_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] div_reg, div_next;
    logic [SIZE_W:0]   trial;

    // One shift and conditional subtract per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, dvd_reg[SEQ_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = SIZE_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[SIZE_W-1:0];
            end
            dvd_next = {dvd_reg[SEQ_W-2:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(SEQ_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

/* hw/rtl/swsb_ctrl.sv */
// Sequencer: read-modify-write of the slot memory for each operation.
module swsb_ctrl
    import swsb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SIZE_W-1:0]      act_size,
    input  logic [MR_W-1:0]        max_resends,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [1:0]             func,
    input  logic [SEQ_W-1:0]       seq_or_ack,
    input  logic [REF_W-1:0]       payload_ref,
    input  logic [LEN_W-1:0]       payload_len,
    input  logic                   last_flag,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [STS_W-1:0]       status,
    output logic [REF_W-1:0]       entry_ref,
    output logic [LEN_W-1:0]       entry_len,
    output logic                   entry_last,
    output logic [RTY_W-1:0]       entry_retries,
    output logic                   window_open,
    output logic                   window_empty,
    output logic [SEQ_W-1:0]       lower_edge,
    output mem_ctl_t               mem_ctl,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_addr,
    output entry_t                 mem_wdata,
    input  entry_t                 mem_rdata,
    output logic                   mod_start,
    output logic [SEQ_W-1:0]       mod_dividend,
    output logic [SIZE_W-1:0]      mod_divisor,
    input  logic                   mod_busy,
    input  logic [SIZE_W-1:0]      mod_rem
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [REF_W-1:0]  pref_reg, pref_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic              plast_reg, plast_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SEQ_W-1:0]  lower_reg, lower_next;
    logic [SEQ_W-1:0]  sent_reg, sent_next;
    logic [SIZE_W-1:0] idx_reg, idx_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0] lo_reg, lo_next;
    logic              any_reg, any_next;
    logic [IW-1:0]     clr_reg, clr_next;
    entry_t            ent_reg, ent_next;

    logic [STS_W-1:0]  res_status_reg, res_status_next;
    logic [REF_W-1:0]  res_ref_reg, res_ref_next;
    logic [LEN_W-1:0]  res_len_reg, res_len_next;
    logic              res_last_reg, res_last_next;
    logic [RTY_W-1:0]  res_rty_reg, res_rty_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [STS_W-1:0]  rsp_status_reg, rsp_status_next;
    logic [REF_W-1:0]  rsp_ref_reg, rsp_ref_next;
    logic [LEN_W-1:0]  rsp_len_reg, rsp_len_next;
    logic              rsp_last_reg, rsp_last_next;
    logic [RTY_W-1:0]  rsp_rty_reg, rsp_rty_next;
    logic              rsp_open_reg, rsp_open_next;
    logic              rsp_empty_reg, rsp_empty_next;
    logic [SEQ_W-1:0]  rsp_lower_reg, rsp_lower_next;

    logic              cand;
    logic              same_sz;
    logic              hit;
    logic              slide_go;
    logic              slide_hit;
    logic              last_k;
    logic              out_free;
    logic [SIZE_W-1:0] lo_inc;
    logic [SEQ_W-1:0]  upper;

    // Decisions on the slot just read.
    assign cand      = mem_rdata.valid && (mem_rdata.seq >= lower_reg)
                       && (mem_rdata.seq < seq_reg);
    assign same_sz   = (mem_rdata.wsz == size_reg);
    assign hit       = mem_rdata.valid && (mem_rdata.seq == seq_reg);
    assign slide_go  = (lower_reg < seq_reg) && (cnt_reg < size_reg);
    assign slide_hit = mem_rdata.valid && (mem_rdata.seq == lower_reg) && mem_rdata.acked;
    assign last_k    = ((cnt_reg + SIZE_W'(1)) == size_reg);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign lo_inc    = lo_reg + SIZE_W'(1);
    assign upper     = lower_reg + SEQ_W'(size_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == IW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (!mod_busy)
                begin
                    state_next = (func_reg == FN_ACK) ? S_A1_RD : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_A1_RD:
            begin
                state_next = S_A1_CHK;
            end
            S_A1_CHK:
            begin
                if (cand && !same_sz)
                begin
                    state_next = S_A1_MOD;
                end
                else
                begin
                    state_next = last_k ? S_A2_RD : S_A1_RD;
                end
            end
            S_A1_MOD:
            begin
                if (!mod_busy)
                begin
                    state_next = last_k ? S_A2_RD : S_A1_RD;
                end
            end
            S_A2_RD:
            begin
                state_next = slide_go ? S_A2_CHK : S_DONE;
            end
            S_A2_CHK:
            begin
                state_next = slide_hit ? S_A2_RD : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory, remainder unit and datapath registers.
    always_comb
    begin
        func_next       = func_reg;
        seq_next        = seq_reg;
        pref_next       = pref_reg;
        plen_next       = plen_reg;
        plast_next      = plast_reg;
        size_next       = size_reg;
        lower_next      = lower_reg;
        sent_next       = sent_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        any_next        = any_reg;
        clr_next        = clr_reg;
        ent_next        = ent_reg;
        res_status_next = res_status_reg;
        res_ref_next    = res_ref_reg;
        res_len_next    = res_len_reg;
        res_last_next   = res_last_reg;
        res_rty_next    = res_rty_reg;
        mem_ctl         = '0;
        mem_addr        = '0;
        mem_wdata       = mem_rdata;
        mod_start       = 1'b0;
        mod_dividend    = seq_or_ack;
        mod_divisor     = act_size;

        case (state_reg)
            // Zero every slot after reset.
            S_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_addr      = clr_reg;
                mem_wdata     = '0;
                clr_next      = clr_reg + IW'(1);
            end
            // Take the word and start the slot index computation.
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next       = func_t'(func);
                    seq_next        = seq_or_ack;
                    pref_next       = payload_ref;
                    plen_next       = payload_len;
                    plast_next      = last_flag;
                    size_next       = act_size;
                    any_next        = 1'b0;
                    cnt_next        = '0;
                    res_status_next = STS_OK;
                    res_ref_next    = '0;
                    res_len_next    = '0;
                    res_last_next   = 1'b0;
                    res_rty_next    = '0;
                    mod_start       = 1'b1;
                    mod_dividend    = (func_t'(func) == FN_ACK) ? lower_reg : seq_or_ack;
                end
            end
            S_MOD:
            begin
                if (!mod_busy)
                begin
                    idx_next = mod_rem;
                    lo_next  = mod_rem;
                end
            end
            S_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_addr      = idx_reg[IW-1:0];
            end
            // Single slot operations.
            S_EXEC:
            begin
                mem_addr = idx_reg[IW-1:0];
                case (func_reg)
                    FN_ADD:
                    begin
                        if (mem_rdata.valid && (mem_rdata.seq != seq_reg))
                        begin
                            res_status_next = STS_COLLISION;
                        end
                        else
                        begin
                            mem_ctl.wr_en   = 1'b1;
                            mem_wdata.valid   = 1'b1;
                            mem_wdata.acked   = 1'b0;
                            mem_wdata.retries = '0;
                            mem_wdata.seq     = seq_reg;
                            mem_wdata.pref    = pref_reg;
                            mem_wdata.plen    = plen_reg;
                            mem_wdata.plast   = plast_reg;
                            mem_wdata.wsz     = size_reg;
                            sent_next         = sent_reg + SEQ_W'(1);
                        end
                    end
                    FN_GET:
                    begin
                        if (hit)
                        begin
                            res_ref_next  = mem_rdata.pref;
                            res_len_next  = mem_rdata.plen;
                            res_last_next = mem_rdata.plast;
                            res_rty_next  = mem_rdata.retries;
                        end
                        else
                        begin
                            res_status_next = STS_NOT_FOUND;
                        end
                    end
                    FN_RESEND:
                    begin
                        if (mem_rdata.retries >= max_resends)
                        begin
                            res_status_next = STS_RETRY_LIMIT;
                        end
                        else if (hit)
                        begin
                            mem_ctl.wr_en     = 1'b1;
                            mem_wdata.retries = mem_rdata.retries + RTY_W'(1);
                            res_ref_next      = mem_rdata.pref;
                            res_len_next      = mem_rdata.plen;
                            res_last_next     = mem_rdata.plast;
                            res_rty_next      = mem_rdata.retries + RTY_W'(1);
                        end
                        else
                        begin
                            res_status_next = STS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_status_next = STS_OK;
                    end
                endcase
            end
            // Ack, marking pass: visit each active slot once.
            S_A1_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_addr      = cnt_reg[IW-1:0];
            end
            S_A1_CHK:
            begin
                mem_addr = cnt_reg[IW-1:0];
                if (cand && same_sz)
                begin
                    mem_ctl.wr_en   = 1'b1;
                    mem_wdata.acked = 1'b1;
                    any_next        = 1'b1;
                end
                else if (cand)
                begin
                    // Slot written under another size: check its home index.
                    ent_next     = mem_rdata;
                    mod_start    = 1'b1;
                    mod_dividend = mem_rdata.seq;
                    mod_divisor  = size_reg;
                end
                if (!(cand && !same_sz))
                begin
                    cnt_next = last_k ? '0 : cnt_reg + SIZE_W'(1);
                end
            end
            S_A1_MOD:
            begin
                mem_addr     = cnt_reg[IW-1:0];
                mem_wdata    = ent_reg;
                mod_divisor  = size_reg;
                if (!mod_busy)
                begin
                    if (mod_rem == cnt_reg)
                    begin
                        mem_ctl.wr_en   = 1'b1;
                        mem_wdata.acked = 1'b1;
                        any_next        = 1'b1;
                    end
                    cnt_next = last_k ? '0 : cnt_reg + SIZE_W'(1);
                end
            end
            // Ack, sliding pass: free consecutive acked slots from the lower edge.
            S_A2_RD:
            begin
                mem_addr = lo_reg[IW-1:0];
                if (slide_go)
                begin
                    mem_ctl.rd_en = 1'b1;
                end
                else
                begin
                    res_status_next = any_reg ? STS_OK : STS_NO_ACK;
                end
            end
            S_A2_CHK:
            begin
                mem_addr = lo_reg[IW-1:0];
                if (slide_hit)
                begin
                    mem_ctl.wr_en   = 1'b1;
                    mem_wdata.valid = 1'b0;
                    lower_next      = lower_reg + SEQ_W'(1);
                    lo_next         = (lo_inc == size_reg) ? '0 : lo_inc;
                    cnt_next        = cnt_reg + SIZE_W'(1);
                end
                else
                begin
                    res_status_next = any_reg ? STS_OK : STS_NO_ACK;
                end
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    // Output register: a finished word waits here while the next is taken.
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_ref_next    = rsp_ref_reg;
        rsp_len_next    = rsp_len_reg;
        rsp_last_next   = rsp_last_reg;
        rsp_rty_next    = rsp_rty_reg;
        rsp_open_next   = rsp_open_reg;
        rsp_empty_next  = rsp_empty_reg;
        rsp_lower_next  = rsp_lower_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = res_status_reg;
            rsp_ref_next    = res_ref_reg;
            rsp_len_next    = res_len_reg;
            rsp_last_next   = res_last_reg;
            rsp_rty_next    = res_rty_reg;
            rsp_open_next   = (sent_reg < upper);
            rsp_empty_next  = (sent_reg == lower_reg);
            rsp_lower_next  = lower_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            lower_reg     <= '0;
            sent_reg      <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lower_reg     <= lower_next;
            sent_reg      <= sent_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        seq_reg        <= seq_next;
        pref_reg       <= pref_next;
        plen_reg       <= plen_next;
        plast_reg      <= plast_next;
        size_reg       <= size_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        lo_reg         <= lo_next;
        any_reg        <= any_next;
        ent_reg        <= ent_next;
        res_status_reg <= res_status_next;
        res_ref_reg    <= res_ref_next;
        res_len_reg    <= res_len_next;
        res_last_reg   <= res_last_next;
        res_rty_reg    <= res_rty_next;
        rsp_status_reg <= rsp_status_next;
        rsp_ref_reg    <= rsp_ref_next;
        rsp_len_reg    <= rsp_len_next;
        rsp_last_reg   <= rsp_last_next;
        rsp_rty_reg    <= rsp_rty_next;
        rsp_open_reg   <= rsp_open_next;
        rsp_empty_reg  <= rsp_empty_next;
        rsp_lower_reg  <= rsp_lower_next;
    end

    assign req_stall     = (state_reg != S_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign status        = rsp_status_reg;
    assign entry_ref     = rsp_ref_reg;
    assign entry_len     = rsp_len_reg;
    assign entry_last    = rsp_last_reg;
    assign entry_retries = rsp_rty_reg;
    assign window_open   = rsp_open_reg;
    assign window_empty  = rsp_empty_reg;
    assign lower_edge    = rsp_lower_reg;

`ifndef SYNTH
    // The single memory port is never asked to read and write at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("slot memory read and write in the same cycle");

    // The send count only ever steps by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sent_reg != $past(sent_reg)) |-> (sent_reg == $past(sent_reg) + SEQ_W'(1)))
        else $error("send count jumped");

    // The lower edge moves only by freeing one slot in the sliding pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lower_reg != $past(lower_reg)) |->
            (($past(state_reg) == S_A2_CHK) && (lower_reg == $past(lower_reg) + SEQ_W'(1))))
        else $error("lower edge moved outside the sliding pass");

    // A new word is never taken while the remainder unit is still busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> !mod_busy)
        else $error("word accepted while remainder unit busy");
`endif

endmodule
